// ----- src/cau_pkg.sv -----
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int DW  = 16;
    localparam int FB  = 8;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 2;
    localparam int NW  = PW;
    localparam int QW  = DW;
    localparam int RW  = PW + QW;
    localparam int QSW = $clog2(QW);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = SW'(D_MAX);
    localparam logic signed [SW-1:0] S_MIN = SW'(D_MIN);
    localparam logic [QW-1:0]        Q_HALF = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic [1:0]           op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic [PW-1:0]        sq_r;
        logic [PW-1:0]        sq_i;
    } t_prod;

    typedef struct packed {
        logic [1:0]           op;
        logic                 dz;
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 sat;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [NW-1:0]        den;
        logic [RW-1:0]        rem_re;
        logic [RW-1:0]        rem_im;
        logic [QW-1:0]        q_re;
        logic [QW-1:0]        q_im;
    } t_pipe;

    typedef struct packed {
        logic signed [DW-1:0] val;
        logic                 sat;
    } t_sat;

    function automatic t_sat sat_fn(input logic signed [SW-1:0] v);
        t_sat r;
        if (v > S_MAX) begin
            r.val = D_MAX;
            r.sat = 1'b1;
        end else if (v < S_MIN) begin
            r.val = D_MIN;
            r.sat = 1'b1;
        end else begin
            r.val = v[DW-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat quo_fn(input logic neg, input logic ovf, input logic [QW-1:0] q);
        t_sat r;
        if (neg) begin
            if (ovf || q > Q_HALF) begin
                r.val = D_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = DW'(QW'(0) - q);
                r.sat = 1'b0;
            end
        end else begin
            if (ovf || q >= Q_HALF) begin
                r.val = D_MAX;
                r.sat = 1'b1;
            end else begin
                r.val = DW'(q);
                r.sat = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ----- src/complex_arithmetic_unit_core.sv -----
// Throughput: one beat per cycle while the output is not stalled; the sixteen-stage restoring divider sets the depth.
// All operations take the same path, so results leave in input order.
// The whole pipeline holds while an output beat is stalled.
// Reset is synchronous and active low and clears only the valid bits.
module complex_arithmetic_unit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_op,
    input  logic signed [cau_pkg::DW-1:0] i_a_real,
    input  logic signed [cau_pkg::DW-1:0] i_a_imag,
    input  logic signed [cau_pkg::DW-1:0] i_b_real,
    input  logic signed [cau_pkg::DW-1:0] i_b_imag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [cau_pkg::DW-1:0] o_res_real,
    output logic signed [cau_pkg::DW-1:0] o_res_imag,
    output logic [1:0]                    o_status
);
    import cau_pkg::*;

    logic                 en;
    logic                 s1_valid;
    t_prod                s1_prod;

    logic                 r_s2_valid;
    logic [1:0]           r_s2_op;
    logic signed [SW-1:0] r_s2_re;
    logic signed [SW-1:0] r_s2_im;
    logic [NW-1:0]        r_s2_den;
    logic signed [SW-1:0] n_s2_re;
    logic signed [SW-1:0] n_s2_im;

    logic                 r_s3_valid;
    t_pipe                r_s3_pipe;
    t_pipe                n_s3_pipe;
    logic signed [SW-1:0] v_re;
    logic signed [SW-1:0] v_im;
    logic signed [SW-1:0] a_re;
    logic signed [SW-1:0] a_im;
    t_sat                 sat_re;
    t_sat                 sat_im;

    logic                 d_valid [QW+1];
    t_pipe                d_pipe  [QW+1];

    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_re;
    logic signed [DW-1:0] r_out_im;
    logic [1:0]           r_out_status;
    logic signed [DW-1:0] n_out_re;
    logic signed [DW-1:0] n_out_im;
    logic [1:0]           n_out_status;
    t_sat                 q_re;
    t_sat                 q_im;
    t_pipe                fin;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    cau_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_ar    (i_a_real),
        .i_ai    (i_a_imag),
        .i_br    (i_b_real),
        .i_bi    (i_b_imag),
        .o_valid (s1_valid),
        .o_prod  (s1_prod)
    );

    always_comb begin
        case (s1_prod.op)
            OP_ADD: begin
                n_s2_re = SW'(s1_prod.ar) + SW'(s1_prod.br);
                n_s2_im = SW'(s1_prod.ai) + SW'(s1_prod.bi);
            end
            OP_SUB: begin
                n_s2_re = SW'(s1_prod.ar) - SW'(s1_prod.br);
                n_s2_im = SW'(s1_prod.ai) - SW'(s1_prod.bi);
            end
            OP_MUL: begin
                n_s2_re = SW'(s1_prod.p_rr) - SW'(s1_prod.p_ii);
                n_s2_im = SW'(s1_prod.p_ri) + SW'(s1_prod.p_ir);
            end
            default: begin
                n_s2_re = SW'(s1_prod.p_rr) + SW'(s1_prod.p_ii);
                n_s2_im = SW'(s1_prod.p_ir) - SW'(s1_prod.p_ri);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op  <= s1_prod.op;
            r_s2_re  <= n_s2_re;
            r_s2_im  <= n_s2_im;
            r_s2_den <= s1_prod.sq_r + s1_prod.sq_i;
        end
    end

    always_comb begin
        v_re   = (r_s2_op == OP_MUL) ? (r_s2_re >>> FB) : r_s2_re;
        v_im   = (r_s2_op == OP_MUL) ? (r_s2_im >>> FB) : r_s2_im;
        sat_re = sat_fn(v_re);
        sat_im = sat_fn(v_im);
        a_re   = (r_s2_re < 0) ? -r_s2_re : r_s2_re;
        a_im   = (r_s2_im < 0) ? -r_s2_im : r_s2_im;

        n_s3_pipe.op     = r_s2_op;
        n_s3_pipe.dz     = (r_s2_den == '0);
        n_s3_pipe.res_re = sat_re.val;
        n_s3_pipe.res_im = sat_im.val;
        n_s3_pipe.sat    = sat_re.sat || sat_im.sat;
        n_s3_pipe.neg_re = (r_s2_re < 0);
        n_s3_pipe.neg_im = (r_s2_im < 0);
        n_s3_pipe.den    = r_s2_den;
        n_s3_pipe.rem_re = RW'({a_re[NW-1:0], {FB{1'b0}}});
        n_s3_pipe.rem_im = RW'({a_im[NW-1:0], {FB{1'b0}}});
        n_s3_pipe.ovf_re = (RW'(a_re[NW-1:0]) >= (RW'(r_s2_den) << FB));
        n_s3_pipe.ovf_im = (RW'(a_im[NW-1:0]) >= (RW'(r_s2_den) << FB));
        n_s3_pipe.q_re   = '0;
        n_s3_pipe.q_im   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_pipe <= n_s3_pipe;
        end
    end

    assign d_valid[0] = r_s3_valid;
    assign d_pipe[0]  = r_s3_pipe;

    for (genvar g = 0; g < QW; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (QSW'(QW - 1 - g)),
            .i_valid (d_valid[g]),
            .i_pipe  (d_pipe[g]),
            .o_valid (d_valid[g+1]),
            .o_pipe  (d_pipe[g+1])
        );
    end

    always_comb begin
        fin  = d_pipe[QW];
        q_re = quo_fn(fin.neg_re, fin.ovf_re, fin.q_re);
        q_im = quo_fn(fin.neg_im, fin.ovf_im, fin.q_im);
        if (fin.op != OP_DIV) begin
            n_out_re     = fin.res_re;
            n_out_im     = fin.res_im;
            n_out_status = fin.sat ? ST_SAT : ST_OK;
        end else if (fin.dz) begin
            n_out_re     = '0;
            n_out_im     = '0;
            n_out_status = ST_DIVZ;
        end else begin
            n_out_re     = q_re.val;
            n_out_im     = q_im.val;
            n_out_status = (q_re.sat || q_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re     <= n_out_re;
            r_out_im     <= n_out_im;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_real = r_out_re;
    assign o_res_imag = r_out_im;
    assign o_status   = r_out_status;
endmodule

// ----- src/cau_prod.sv -----
// First pipeline stage: registers the operands and all partial products.
module cau_prod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [1:0]                   i_op,
    input  logic signed [cau_pkg::DW-1:0] i_ar,
    input  logic signed [cau_pkg::DW-1:0] i_ai,
    input  logic signed [cau_pkg::DW-1:0] i_br,
    input  logic signed [cau_pkg::DW-1:0] i_bi,
    output logic                         o_valid,
    output cau_pkg::t_prod               o_prod
);
    import cau_pkg::*;

    logic  r_valid;
    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.op   = i_op;
        n_prod.ar   = i_ar;
        n_prod.ai   = i_ai;
        n_prod.br   = i_br;
        n_prod.bi   = i_bi;
        n_prod.p_rr = PW'(i_ar) * PW'(i_br);
        n_prod.p_ii = PW'(i_ai) * PW'(i_bi);
        n_prod.p_ri = PW'(i_ar) * PW'(i_bi);
        n_prod.p_ir = PW'(i_ai) * PW'(i_br);
        n_prod.sq_r = PW'(i_br * i_br);
        n_prod.sq_i = PW'(i_bi * i_bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
endmodule

// ----- src/cau_div_step.sv -----
// One restoring division step applied to both result parts.
module cau_div_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [cau_pkg::QSW-1:0]    i_shift,
    input  logic                       i_valid,
    input  cau_pkg::t_pipe             i_pipe,
    output logic                       o_valid,
    output cau_pkg::t_pipe             o_pipe
);
    import cau_pkg::*;

    logic          r_valid;
    t_pipe         r_pipe;
    t_pipe         n_pipe;
    logic [RW-1:0] trial;

    always_comb begin
        trial  = RW'(i_pipe.den) << i_shift;
        n_pipe = i_pipe;
        if (i_pipe.rem_re >= trial) begin
            n_pipe.rem_re          = i_pipe.rem_re - trial;
            n_pipe.q_re[i_shift]   = 1'b1;
        end
        if (i_pipe.rem_im >= trial) begin
            n_pipe.rem_im          = i_pipe.rem_im - trial;
            n_pipe.q_im[i_shift]   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;
endmodule

// ----- dv/complex_arithmetic_unit_core_tb.sv -----
// Self-checking testbench for the complex arithmetic unit with directed rows and random beats.
module complex_arithmetic_unit_core_tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } t_operands;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [1:0]           st;
    } t_answer;

    typedef struct packed {
        t_operands opnd;
        logic      known;
        t_answer   ans;
    } t_row;

    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_op;
    logic signed [DW-1:0] i_a_real;
    logic signed [DW-1:0] i_a_imag;
    logic signed [DW-1:0] i_b_real;
    logic signed [DW-1:0] i_b_imag;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [DW-1:0] o_res_real;
    logic signed [DW-1:0] o_res_imag;
    logic [1:0]           o_status;

    t_answer   expected_q[$];
    t_row      rows[$];
    int        errors;
    int        n_results;
    int        n_sat;
    int        n_divz;
    longint    cycles;
    bit        stall_mode;

    complex_arithmetic_unit_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_a_real   (i_a_real),
        .i_a_imag   (i_a_imag),
        .i_b_real   (i_b_real),
        .i_b_imag   (i_b_imag),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_real (o_res_real),
        .o_res_imag (o_res_imag),
        .o_status   (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [DW-1:0] clamp(input longint v, inout bit sat);
        if (v > longint'(D_MAX)) begin
            sat = 1'b1;
            return D_MAX;
        end
        if (v < longint'(D_MIN)) begin
            sat = 1'b1;
            return D_MIN;
        end
        return v[DW-1:0];
    endfunction

    // Quotient rounded toward zero.
    function automatic longint div_trunc(input longint n, input longint d);
        longint q;
        q = (n < 0 ? -n : n) * (longint'(1) << FB) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic t_answer complex_result(input t_operands x);
        t_answer r;
        longint  ar, ai, br, bi, re, im, den;
        bit      sat;
        ar = x.ar;
        ai = x.ai;
        br = x.br;
        bi = x.bi;
        sat = 1'b0;
        case (x.op)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = ST_DIVZ;
                    return r;
                end
                re = div_trunc(ar * br + ai * bi, den);
                im = div_trunc(ai * br - ar * bi, den);
            end
        endcase
        r.re = clamp(re, sat);
        r.im = clamp(im, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(0, 9))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3, 4: return DW'($signed($urandom_range(0, 1023)) - 512);
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic t_row make_row(input logic [1:0] op, input int ar, input int ai,
                                      input int br, input int bi, input bit known,
                                      input int re, input int im, input logic [1:0] st);
        t_row r;
        r.opnd.op = op;
        r.opnd.ar = DW'(ar);
        r.opnd.ai = DW'(ai);
        r.opnd.br = DW'(br);
        r.opnd.bi = DW'(bi);
        r.known   = known;
        r.ans.re  = DW'(re);
        r.ans.im  = DW'(im);
        r.ans.st  = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
            i_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results <= n_results + 1;
            if (o_status == ST_SAT) n_sat <= n_sat + 1;
            if (o_status == ST_DIVZ) n_divz <= n_divz + 1;
            if (expected_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("Unexpected result beat: %0d %0d %0d",
                                          o_res_real, o_res_imag, o_status);
            end else begin
                want = expected_q.pop_front();
                if (o_res_real !== want.re || o_res_imag !== want.im || o_status !== want.st)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("Mismatch: expected %0d %0d st %0d, got %0d %0d st %0d",
                                 want.re, want.im, want.st, o_res_real, o_res_imag,
                                 o_status);
                end
            end
        end
    end

    task automatic send(input t_operands x, input t_answer want);
        i_valid  <= 1'b1;
        i_op     <= x.op;
        i_a_real <= x.ar;
        i_a_imag <= x.ai;
        i_b_real <= x.br;
        i_b_imag <= x.bi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(want);
    endtask

    initial begin
        t_operands x;
        t_answer   want;
        int        burst;
        int        sent;
        int        drain;
        cycles     = 0;
        errors     = 0;
        n_results  = 0;
        n_sat      = 0;
        n_divz     = 0;
        stall_mode = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_op       = OP_ADD;
        i_a_real   = '0;
        i_a_imag   = '0;
        i_b_real   = '0;
        i_b_imag   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(make_row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        rows.push_back(make_row(OP_ADD, 32767, 32767, 1, -32768, 1, 32767, -1, ST_SAT));
        rows.push_back(make_row(OP_ADD, -32768, 0, -1, 0, 1, -32768, 0, ST_SAT));
        rows.push_back(make_row(OP_SUB, -32768, 32767, 1, -1, 1, -32768, 32767, ST_SAT));
        rows.push_back(make_row(OP_SUB, 100, 50, 30, 70, 1, 70, -20, ST_OK));
        rows.push_back(make_row(OP_SUB, 0, 0, -32768, 0, 1, 32767, 0, ST_SAT));
        rows.push_back(make_row(OP_MUL, 256, 0, 512, 256, 1, 512, 256, ST_OK));
        rows.push_back(make_row(OP_MUL, -1, 0, 1, 0, 1, -1, 0, ST_OK));
        rows.push_back(make_row(OP_MUL, -32768, -32768, -32768, -32768, 0, 0, 0, ST_OK));
        rows.push_back(make_row(OP_MUL, 32767, -32768, 32767, 32767, 0, 0, 0, ST_OK));
        rows.push_back(make_row(OP_DIV, 1234, -99, 0, 0, 1, 0, 0, ST_DIVZ));
        rows.push_back(make_row(OP_DIV, -32768, 32767, 0, 0, 1, 0, 0, ST_DIVZ));
        rows.push_back(make_row(OP_DIV, 512, 256, 256, 0, 1, 512, 256, ST_OK));
        rows.push_back(make_row(OP_DIV, 32767, 32767, 1, 0, 1, 32767, 32767, ST_SAT));
        rows.push_back(make_row(OP_DIV, -32768, 0, 1, 0, 1, -32768, 0, ST_SAT));
        rows.push_back(make_row(OP_DIV, -1, 1, 32767, -32768, 0, 0, 0, ST_OK));
        rows.push_back(make_row(OP_DIV, -32768, -32768, -32768, -32768, 0, 0, 0, ST_OK));
        rows.push_back(make_row(OP_DIV, 100, -100, 3, 7, 0, 0, 0, ST_OK));
        rows.push_back(make_row(OP_DIV, -300, 5, 0, -1, 0, 0, 0, ST_OK));

        foreach (rows[k]) begin
            want = rows[k].known ? rows[k].ans : complex_result(rows[k].opnd);
            send(rows[k].opnd, want);
        end
        i_valid <= 1'b0;

        // Let the pipeline empty completely before the random traffic starts.
        while (expected_q.size() != 0) @(posedge i_clk);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < N_RANDOM) begin
                x.op = 2'($urandom_range(0, 3));
                x.ar = rand_part();
                x.ai = rand_part();
                x.br = rand_part();
                x.bi = rand_part();
                if (x.op == OP_DIV && $urandom_range(0, 19) == 0) begin
                    x.br = '0;
                    x.bi = '0;
                end
                send(x, complex_result(x));
                burst--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < DRAIN) begin
            @(posedge i_clk);
            drain++;
        end

        $display("Checked %0d results over all four operations.", n_results);
        $display("Saturated results: %0d, division by zero results: %0d.", n_sat, n_divz);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("Failures: %0d.", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cau_pkg.sv
src/cau_prod.sv
src/cau_div_step.sv
src/complex_arithmetic_unit_core.sv
dv/complex_arithmetic_unit_core_tb.sv
